// ===== rtl/ammf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ammf_pkg
// Shared types, widths and constants of the accelerometer motion filter.
// ----------------------------------------------------------------------------
package ammf_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int WINDOW_MAX = 16;

    localparam int AXIS_W  = 16;
    localparam int LIN_W   = 17;
    localparam int MAG_W   = 17;
    localparam int GRAV_W  = 32;
    localparam int ALPHA_W = 16;
    localparam int SQ_W    = 34;
    localparam int SUB_W   = 21;
    localparam int PROD_W  = 50;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd58982;
    localparam logic [MAG_W-1:0]   MAG_MAX     = 17'd113510;

    localparam int  PADDR_W   = 3;
    localparam int  PDATA_W   = 32;
    localparam logic REG_ALPHA = 1'b0;

    typedef struct packed {
        logic start;
        logic ack;
    } t_core_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MA   = 11'b000_0000_0010,
        S_MB   = 11'b000_0000_0100,
        S_UPD  = 11'b000_0000_1000,
        S_LIN  = 11'b000_0001_0000,
        S_SQM  = 11'b000_0010_0000,
        S_SQA  = 11'b000_0100_0000,
        S_SQRT = 11'b000_1000_0000,
        S_WIN  = 11'b001_0000_0000,
        S_DIV  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/ammf_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ammf_core
// Sequenced datapath: one shared multiplier for the gravity filters and the
// squares, one shared subtractor for the bit-serial root and the divider.
// ----------------------------------------------------------------------------
module ammf_core #(
    parameter int WINDOW = ammf_pkg::WINDOW_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire ammf_pkg::t_core_ctl                i_ctl,
    output ammf_pkg::t_core_sts                     o_sts,
    input  wire [ammf_pkg::ALPHA_W-1:0]             i_alpha,
    input  wire signed [ammf_pkg::AXIS_W-1:0]       i_accel_x,
    input  wire signed [ammf_pkg::AXIS_W-1:0]       i_accel_y,
    input  wire signed [ammf_pkg::AXIS_W-1:0]       i_accel_z,
    output logic signed [ammf_pkg::LIN_W-1:0]       o_linear_x,
    output logic signed [ammf_pkg::LIN_W-1:0]       o_linear_y,
    output logic signed [ammf_pkg::LIN_W-1:0]       o_linear_z,
    output logic [ammf_pkg::MAG_W-1:0]              o_magnitude,
    output logic [ammf_pkg::MAG_W-1:0]              o_smoothed_magnitude
);

    localparam int MAG_W = ammf_pkg::MAG_W;
    localparam int SUB_W = ammf_pkg::SUB_W;
    localparam int SQ_W  = ammf_pkg::SQ_W;
    localparam int PROD_W = ammf_pkg::PROD_W;
    localparam int GRAV_W = ammf_pkg::GRAV_W;
    localparam int AXIS_W = ammf_pkg::AXIS_W;
    localparam int LIN_W  = ammf_pkg::LIN_W;
    localparam int SUM_W = MAG_W + $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int IT_W  = 5;

    ammf_pkg::t_state r_state, n_state;

    logic [1:0]                       r_ax;
    logic signed [AXIS_W-1:0]         r_x   [3];
    logic signed [GRAV_W-1:0]         r_g   [3];
    logic signed [LIN_W-1:0]          r_lin [3];
    logic signed [PROD_W-1:0]         r_prod;
    logic signed [PROD_W-1:0]         r_acc;
    logic [SQ_W-1:0]                  r_sq;
    logic [MAG_W-1:0]                 r_root;
    logic [SUB_W-1:0]                 r_rem;
    logic [IT_W-1:0]                  r_it;
    logic [PTR_W-1:0]                 r_ptr;
    logic                             r_full;
    logic [SUM_W-1:0]                 r_sum;
    logic [SUM_W-1:0]                 r_dq;
    logic [CNT_W-1:0]                 r_cnt;
    logic [MAG_W-1:0]                 r_old;
    logic [MAG_W-1:0]                 r_win [WINDOW];

    logic signed [17:0]               w_mul_a;
    logic signed [31:0]               w_mul_b;
    logic signed [PROD_W-1:0]         w_prod;
    logic signed [PROD_W-1:0]         w_tot;
    logic signed [PROD_W-1:0]         w_ng;
    logic signed [GRAV_W:0]           w_gr;
    logic signed [17:0]               w_lin;
    logic [SUB_W-1:0]                 w_sub_a;
    logic [SUB_W-1:0]                 w_sub_b;
    logic [SUB_W:0]                   w_diff;
    logic                             w_ge;
    logic [CNT_W-1:0]                 w_ptr_inc;
    logic                             w_wrap;
    logic [SUM_W-1:0]                 w_nsum;

    // shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ammf_pkg::S_MA: begin
                w_mul_a = $signed({2'b00, i_alpha});
                w_mul_b = r_g[r_ax];
            end
            ammf_pkg::S_MB: begin
                w_mul_a = 18'sd65536 - $signed({2'b00, i_alpha});
                w_mul_b = {{(32-AXIS_W){r_x[r_ax][AXIS_W-1]}}, r_x[r_ax]};
            end
            ammf_pkg::S_SQM: begin
                w_mul_a = {r_lin[r_ax][LIN_W-1], r_lin[r_ax]};
                w_mul_b = {{(32-LIN_W){r_lin[r_ax][LIN_W-1]}}, r_lin[r_ax]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_tot  = r_acc + (r_prod <<< 16);
    assign w_ng   = w_tot >>> 16;
    assign w_gr   = {r_g[r_ax][GRAV_W-1], r_g[r_ax]} + 33'sd32768;
    assign w_lin  = $signed({{2{r_x[r_ax][AXIS_W-1]}}, r_x[r_ax]})
                  - $signed({w_gr[GRAV_W], w_gr[GRAV_W:16]});

    // shared subtract and compare
    always_comb begin
        if (r_state == ammf_pkg::S_SQRT) begin
            w_sub_a = {r_rem[SUB_W-3:0], r_sq[SQ_W-1 -: 2]};
            w_sub_b = {2'b00, r_root, 2'b01};
        end else begin
            w_sub_a = SUB_W'({r_rem[CNT_W-1:0], r_dq[SUM_W-1]});
            w_sub_b = SUB_W'(r_cnt);
        end
    end

    assign w_diff = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_ge   = ~w_diff[SUB_W];

    assign w_ptr_inc = CNT_W'(r_ptr) + CNT_W'(1);
    assign w_wrap    = (w_ptr_inc == CNT_W'(WINDOW));
    assign w_nsum    = r_sum - (r_full ? SUM_W'(r_old) : '0) + SUM_W'(r_root);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ammf_pkg::S_IDLE: if (i_ctl.start) n_state = ammf_pkg::S_MA;
            ammf_pkg::S_MA:   n_state = ammf_pkg::S_MB;
            ammf_pkg::S_MB:   n_state = ammf_pkg::S_UPD;
            ammf_pkg::S_UPD:  n_state = ammf_pkg::S_LIN;
            ammf_pkg::S_LIN:  n_state = (r_ax == 2'd2) ? ammf_pkg::S_SQM : ammf_pkg::S_MA;
            ammf_pkg::S_SQM:  n_state = ammf_pkg::S_SQA;
            ammf_pkg::S_SQA:  n_state = (r_ax == 2'd2) ? ammf_pkg::S_SQRT : ammf_pkg::S_SQM;
            ammf_pkg::S_SQRT: if (r_it == IT_W'(MAG_W - 1)) n_state = ammf_pkg::S_WIN;
            ammf_pkg::S_WIN:  n_state = ammf_pkg::S_DIV;
            ammf_pkg::S_DIV:  if (r_it == IT_W'(SUM_W - 1)) n_state = ammf_pkg::S_DONE;
            ammf_pkg::S_DONE: if (i_ctl.ack) n_state = ammf_pkg::S_IDLE;
            default:          n_state = ammf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ammf_pkg::S_IDLE;
            r_ax    <= '0;
            r_it    <= '0;
            r_ptr   <= '0;
            r_full  <= 1'b0;
            r_sum   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ammf_pkg::S_IDLE: begin
                    r_ax <= '0;
                end
                ammf_pkg::S_UPD: begin
                    r_g[r_ax] <= w_ng[GRAV_W-1:0];
                end
                ammf_pkg::S_LIN: begin
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                ammf_pkg::S_SQA: begin
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    r_it <= '0;
                end
                ammf_pkg::S_SQRT: begin
                    r_it <= (r_it == IT_W'(MAG_W - 1)) ? '0 : r_it + IT_W'(1);
                end
                ammf_pkg::S_WIN: begin
                    r_ptr  <= w_wrap ? '0 : r_ptr + PTR_W'(1);
                    r_full <= r_full | w_wrap;
                    r_sum  <= w_nsum;
                    r_it   <= '0;
                end
                ammf_pkg::S_DIV: begin
                    r_it <= r_it + IT_W'(1);
                end
                default: begin
                    r_ax <= r_ax;
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ammf_pkg::S_IDLE: begin
                r_x[0] <= i_accel_x;
                r_x[1] <= i_accel_y;
                r_x[2] <= i_accel_z;
            end
            ammf_pkg::S_MA: begin
                r_prod <= w_prod;
            end
            ammf_pkg::S_MB: begin
                r_acc  <= r_prod;
                r_prod <= w_prod;
            end
            ammf_pkg::S_LIN: begin
                r_lin[r_ax] <= w_lin[LIN_W-1:0];
                r_sq        <= '0;
            end
            ammf_pkg::S_SQM: begin
                r_prod <= w_prod;
            end
            ammf_pkg::S_SQA: begin
                r_sq   <= r_sq + r_prod[SQ_W-1:0];
                r_root <= '0;
                r_rem  <= '0;
            end
            ammf_pkg::S_SQRT: begin
                r_rem  <= w_ge ? w_diff[SUB_W-1:0] : w_sub_a;
                r_root <= {r_root[MAG_W-2:0], w_ge};
                r_sq   <= {r_sq[SQ_W-3:0], 2'b00};
            end
            ammf_pkg::S_WIN: begin
                r_win[r_ptr] <= r_root;
                r_cnt        <= (r_full | w_wrap) ? CNT_W'(WINDOW) : w_ptr_inc;
                r_dq         <= w_nsum;
                r_rem        <= '0;
            end
            ammf_pkg::S_DIV: begin
                r_rem <= w_ge ? w_diff[SUB_W-1:0] : w_sub_a;
                r_dq  <= {r_dq[SUM_W-2:0], w_ge};
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        r_old <= r_win[r_ptr];
    end

    assign o_sts.idle = (r_state == ammf_pkg::S_IDLE);
    assign o_sts.done = (r_state == ammf_pkg::S_DONE);

    assign o_linear_x           = r_lin[0];
    assign o_linear_y           = r_lin[1];
    assign o_linear_z           = r_lin[2];
    assign o_magnitude          = r_root;
    assign o_smoothed_magnitude = r_dq[MAG_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/accel_motion_magnitude_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// accel_motion_magnitude_filter
// Gravity removal, vector magnitude and windowed mean of three-axis samples.
// A request is taken only while the core is idle; a new one is not accepted until
// the previous result has been handed to the output register. The core uses the shared
// multiplier for each axis in turn, then for the squares, takes 17 root steps and one
// divider step per bit of the window sum.
// Reset: gravity estimates and window sum cleared, window empty, alpha 58982.
// ----------------------------------------------------------------------------
module accel_motion_magnitude_filter #(
    parameter int WINDOW = ammf_pkg::WINDOW_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x, accel_y, accel_z
    input  wire [47:0]                          s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // linear_x, linear_y, linear_z, magnitude, smoothed_magnitude, zero pad
    output logic [87:0]                         m_axis_tdata,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [ammf_pkg::PADDR_W-1:0]         paddr,
    input  wire [ammf_pkg::PDATA_W-1:0]         pwdata,
    output logic [ammf_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int MAG_W = ammf_pkg::MAG_W;
    localparam int LIN_W = ammf_pkg::LIN_W;

    logic [ammf_pkg::ALPHA_W-1:0] r_alpha;
    logic                         r_mvalid;
    logic [87:0]                  r_mdata;

    ammf_pkg::t_core_ctl          w_ctl;
    ammf_pkg::t_core_sts          w_sts;
    logic signed [LIN_W-1:0]      w_lx, w_ly, w_lz;
    logic [MAG_W-1:0]             w_mag, w_smooth;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign prdata = (paddr[2] == ammf_pkg::REG_ALPHA) ?
                    ammf_pkg::PDATA_W'(r_alpha) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ammf_pkg::ALPHA_RESET;
        end else if (w_wr && paddr[2] == ammf_pkg::REG_ALPHA) begin
            r_alpha <= pwdata[ammf_pkg::ALPHA_W-1:0];
        end
    end

    assign s_axis_tready = w_sts.idle;
    assign w_ctl.start   = s_axis_tvalid & s_axis_tready;
    assign w_ctl.ack     = w_sts.done & (~r_mvalid | m_axis_tready);

    ammf_core #(
        .WINDOW(WINDOW)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctl                (w_ctl),
        .o_sts                (w_sts),
        .i_alpha              (r_alpha),
        .i_accel_x            (s_axis_tdata[15:0]),
        .i_accel_y            (s_axis_tdata[31:16]),
        .i_accel_z            (s_axis_tdata[47:32]),
        .o_linear_x           (w_lx),
        .o_linear_y           (w_ly),
        .o_linear_z           (w_lz),
        .o_magnitude          (w_mag),
        .o_smoothed_magnitude (w_smooth)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_ctl.ack) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ack) begin
            r_mdata <= {3'b000, w_smooth, w_mag, w_lz, w_ly, w_lx};
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

    a_ack_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ack |=> m_axis_tvalid)
        else $error("result not presented after core completion");

    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |=> !w_sts.idle)
        else $error("core stayed idle after request");

    a_ack_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ack |=> w_sts.idle)
        else $error("core not idle after result handover");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[67:51] <= ammf_pkg::MAG_MAX)
                       && (m_axis_tdata[84:68] <= ammf_pkg::MAG_MAX))
        else $error("magnitude out of range");

endmodule
`default_nettype wire

// ===== dv/accel_motion_magnitude_filter_test.sv =====
// ----------------------------------------------------------------------------
// accel_motion_magnitude_filter_test
// Streams three-axis samples through the motion filter under random back
// pressure and compares every result, field by field, against a cycle-free
// predictor of gravity tracking, vector magnitude and the windowed mean.
// ----------------------------------------------------------------------------
module accel_motion_magnitude_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ammf_pkg::*;

    localparam logic [PADDR_W-1:0] ALPHA_ADDR   = PADDR_W'(4 * REG_ALPHA);
    localparam int                 DRAIN_CYCLES = 80;
    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 PHASES       = 6;
    localparam int                 PHASE_ITEMS  = 75;

    typedef struct {
        logic [LIN_W-1:0] lin_x;
        logic [LIN_W-1:0] lin_y;
        logic [LIN_W-1:0] lin_z;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] avg;
    } motion_result_t;

    class motion_scoreboard;
        logic [ALPHA_W-1:0] alpha;
        int                 gravity[3];
        logic [MAG_W-1:0]   mag_hist[WINDOW_DEF];
        int unsigned        slot;
        bit                 filled;
        int unsigned        mag_sum;
        motion_result_t     awaited[$];
        int unsigned        samples_in;
        int unsigned        results_out;
        int unsigned        mismatches;

        function new();
            alpha       = ALPHA_RESET;
            gravity     = '{0, 0, 0};
            slot        = 0;
            filled      = 1'b0;
            mag_sum     = 0;
            samples_in  = 0;
            results_out = 0;
            mismatches  = 0;
        endfunction

        function logic [LIN_W-1:0] track_axis(int axis, logic signed [AXIS_W-1:0] x);
            longint a;
            longint acc;
            longint est;
            a   = alpha;
            acc = a * longint'(gravity[axis]) + (longint'(65536) - a) * (longint'(x) <<< 16);
            est = acc >>> 16;
            gravity[axis] = int'(est);
            return LIN_W'(longint'(x) - ((est + 32768) >>> 16));
        endfunction

        function logic [MAG_W-1:0] root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = MAG_W; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return MAG_W'(r);
        endfunction

        function void note_sample(logic signed [AXIS_W-1:0] x, logic signed [AXIS_W-1:0] y,
                                  logic signed [AXIS_W-1:0] z);
            motion_result_t due;
            longint         sx;
            longint         sy;
            longint         sz;
            due.lin_x = track_axis(0, x);
            due.lin_y = track_axis(1, y);
            due.lin_z = track_axis(2, z);
            sx = longint'($signed(due.lin_x));
            sy = longint'($signed(due.lin_y));
            sz = longint'($signed(due.lin_z));
            due.mag = root_floor(sx * sx + sy * sy + sz * sz);
            if (filled) mag_sum -= mag_hist[slot];
            mag_hist[slot] = due.mag;
            mag_sum += due.mag;
            slot++;
            if (slot == WINDOW_DEF) begin
                slot   = 0;
                filled = 1'b1;
            end
            due.avg = MAG_W'(mag_sum / (filled ? WINDOW_DEF : slot));
            awaited.push_back(due);
            samples_in++;
        endfunction

        function void compare_field(string name, logic [16:0] want, logic [16:0] seen,
                                    bit is_signed);
            if (seen !== want) begin
                mismatches++;
                if (is_signed)
                    $error("%s: expected %0d, got %0d", name, $signed(want), $signed(seen));
                else
                    $error("%s: expected %0d, got %0d", name, want, seen);
            end
        endfunction

        function void check_result(logic [87:0] d);
            motion_result_t due;
            results_out++;
            if (awaited.size() == 0) begin
                mismatches++;
                $error("result with no sample outstanding: %h", d);
                return;
            end
            due = awaited.pop_front();
            compare_field("linear_x", due.lin_x, d[16:0], 1'b1);
            compare_field("linear_y", due.lin_y, d[33:17], 1'b1);
            compare_field("linear_z", due.lin_z, d[50:34], 1'b1);
            compare_field("magnitude", due.mag, d[67:51], 1'b0);
            compare_field("smoothed_magnitude", due.avg, d[84:68], 1'b0);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // accel_x, accel_y, accel_z
    logic [47:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // linear_x, linear_y, linear_z, magnitude, smoothed_magnitude, zero pad
    logic [87:0]          m_axis_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    motion_scoreboard sb;
    bit               steady;
    int               rx_hold_req;
    int unsigned      alpha_settings;

    accel_motion_magnitude_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int hold_left;
        m_axis_tready = 1'b0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req != 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic set_alpha(logic [ALPHA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ALPHA_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.alpha = value;
        alpha_settings++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== PDATA_W'(value)) begin
            sb.mismatches++;
            $error("alpha_coeff: expected %0d, got %0d", value, readback);
        end
    endtask

    task automatic send_sample(logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y,
                               logic [AXIS_W-1:0] z);
        while (!steady && $urandom_range(0, 99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(x, y, z);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sb.awaited.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [AXIS_W-1:0] corner_vals[7];
        int                phase_alpha[PHASES];
        int                vals[3];
        int                kind;
        int                g_axis;
        int                noise;
        bit                passed;

        corner_vals = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFE, 16'h7FFF};
        phase_alpha = '{58982, 65535, 0, 0, 32768, 1};
        phase_alpha[3] = $urandom_range(2, 65533);

        sb             = new();
        steady         = 1'b0;
        rx_hold_req    = 0;
        alpha_settings = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset alpha: extremes, window fill and wrap
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000, 16'h0000);
        send_sample(16'hFFFF, 16'h0001, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
        s_axis_tvalid <= 1'b0;
        drain();

        // alpha zero: estimate follows the sample
        set_alpha(16'd0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'd12345, 16'hF752, 16'h7FFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        s_axis_tvalid <= 1'b0;
        drain();

        // slowest tracking after a full-scale estimate: largest magnitudes
        set_alpha(16'hFFFF);
        repeat (3) send_sample(16'h8000, 16'h8000, 16'h8000);
        repeat (2) send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        s_axis_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_alpha(16'(phase_alpha[p]));
            steady = (p == 1);
            if (p == 2) rx_hold_req = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 3 && n == 40) begin
                    s_axis_tvalid <= 1'b0;
                    drain();
                end
                kind = $urandom_range(0, 99);
                if (kind < 50) begin
                    // resting sensor: gravity on one axis plus noise
                    g_axis = $urandom_range(0, 2);
                    for (int k = 0; k < 3; k++) vals[k] = int'($urandom_range(0, 4000)) - 2000;
                    noise = int'($urandom_range(0, 8000)) - 4000;
                    vals[g_axis] = ($urandom_range(0, 1) ? 16384 : -16384) + noise;
                end else if (kind < 85) begin
                    for (int k = 0; k < 3; k++) vals[k] = int'($urandom_range(0, 65535));
                end else begin
                    for (int k = 0; k < 3; k++) vals[k] = corner_vals[$urandom_range(0, 6)];
                end
                send_sample(16'(vals[0]), 16'(vals[1]), 16'(vals[2]));
            end
            s_axis_tvalid <= 1'b0;
            steady = 1'b0;
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        passed = (sb.mismatches == 0) && (sb.awaited.size() == 0);
        if (sb.awaited.size() != 0) $error("%0d results never arrived", sb.awaited.size());
        $display("summary: %0d samples, %0d results checked, %0d mismatches",
                 sb.samples_in, sb.results_out, sb.mismatches);
        $display("summary: %0d alpha writes incl. 0 and 65535, long output stall, drained pauses",
                 alpha_settings);
        if (passed) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
